/* sv/mfgw_pkg.sv */
`timescale 1ns / 1ps

package mfgw_pkg;

  // operation codes carried on the mode field
  typedef enum logic [2:0] {
    MODE_FILL   = 3'd0,
    MODE_PIXEL  = 3'd1,
    MODE_CURSOR = 3'd2,
    MODE_CHAR   = 3'd3,
    MODE_FONT   = 3'd4,
    MODE_READ   = 3'd5
  } mode_t;

  // configuration register indexes
  localparam logic [1:0] CFG_INVERT      = 2'd0;
  localparam logic [1:0] CFG_FONT_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_FONT_HEIGHT = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 6;

  // printable character range
  localparam logic [7:0] FIRST_CHAR = 8'd32;

  localparam logic [4:0] FONT_WIDTH_RESET  = 5'd7;
  localparam logic [5:0] FONT_HEIGHT_RESET = 6'd10;

endpackage

/* sv/mono_framebuffer_glyph_writer_unit.sv */
`timescale 1ns / 1ps

// sequencing (start to done): cursor, font load, refused and unused ops finish straight from idle;
//   pixel draw and byte read pass a read state and a result state; fill sweeps every byte;
//   char render walks the glyph base, then for each glyph row reads the row and does
//   one read-modify-write of the pixel ram per column
// throughput: one transaction at a time, next start taken the cycle busy drops
// reset: a clearing pass writes every frame buffer byte to zero, one byte a cycle
//   (SCREEN_WIDTH*pages bytes, 1024 by default) with busy high; the glyph ram is not cleared
// the receiver cannot stall: done stands for exactly one cycle, its result holds until the next start is taken
module mono_framebuffer_glyph_writer_unit #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int GLYPH_ROWS    = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        mode,
  input  logic [7:0]                        x,
  input  logic [7:0]                        y,
  input  logic                              color,
  input  logic [7:0]                        ch,
  input  logic [11:0]                       font_index,
  input  logic [15:0]                       font_row,
  input  logic [9:0]                        read_address,
  // result channel
  output logic                              done,
  output logic                              accepted,
  output logic [7:0]                        written_char,
  output logic [7:0]                        read_data,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [mfgw_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mfgw_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import mfgw_pkg::*;

  localparam int PAGES       = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int GAW         = $clog2(GLYPH_ROWS);

  // sequencer states
  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_FILL    = 10'b00_0000_0010,
    S_PIX_RD  = 10'b00_0000_0100,
    S_PIX_WR  = 10'b00_0000_1000,
    S_RD_REQ  = 10'b00_0001_0000,
    S_RD_DATA = 10'b00_0010_0000,
    S_BASE    = 10'b00_0100_0000,
    S_GROW    = 10'b00_1000_0000,
    S_COLS    = 10'b01_0000_0000,
    S_RNEXT   = 10'b10_0000_0000
  } state_t;

  state_t state;

  // configuration registers
  logic       invert;
  logic [4:0] font_width;
  logic [5:0] font_height;

  // text cursor
  logic [7:0] cursor_col;
  logic [7:0] cursor_row;

  // per-transaction working registers
  logic [AW-1:0]  saddr;      // read address for pixel draw and byte read
  logic [AW-1:0]  faddr;      // fill sweep address
  logic           fill_val;
  logic           fill_rep;   // fill came from a command, not reset
  logic           color_l;
  logic [7:0]     ch_l;
  logic [6:0]     kcnt;       // glyph base steps left
  logic [GAW-1:0] gptr;       // current glyph row
  logic [5:0]     rcnt;
  logic [4:0]     ccnt;

  // pending read-modify-write, completes the cycle after its read
  logic           pend;
  logic [AW-1:0]  pend_addr;
  logic [7:0]     pend_mask;
  logic           pend_val;

  // memory ports
  logic           pix_we;
  logic [AW-1:0]  pix_waddr;
  logic [7:0]     pix_wdata;
  logic [AW-1:0]  pix_raddr;
  logic [7:0]     pix_q;
  logic           gly_we;
  logic [GAW-1:0] gly_waddr;
  logic [15:0]    gly_q;

  // combinational helpers
  logic           take;
  logic           pix_ok;
  logic           char_ok;
  logic           fit_ok;
  logic           font_ok;
  logic           read_ok;
  logic [AW-1:0]  pix_addr;
  logic [8:0]     ren_py;
  logic [AW-1:0]  ren_addr;
  logic           ren_fg;
  logic           ren_val;
  logic [GAW:0]   base_sum;
  logic [GAW-1:0] base_next;
  logic [GAW:0]   row_sum;
  logic [GAW-1:0] row_next;

  assign busy = (state != S_IDLE);
  assign take = start && !busy;

  // range checks on the incoming command
  assign pix_ok  = ({1'b0, x} < 9'(SCREEN_WIDTH)) && ({1'b0, y} < 9'(SCREEN_HEIGHT));
  assign char_ok = (ch >= FIRST_CHAR) && !ch[7];
  // glyph must stay clear of the right and bottom edge
  assign fit_ok  = (({1'b0, cursor_col} + {4'd0, font_width}) < 9'(SCREEN_WIDTH)) &&
                   (({1'b0, cursor_row} + {3'd0, font_height}) < 9'(SCREEN_HEIGHT));
  assign font_ok = ({20'd0, font_index} < 32'(GLYPH_ROWS));
  assign read_ok = ({22'd0, read_address} < 32'(STORE_BYTES));

  // byte address: page times width plus column
  assign pix_addr = AW'(32'(y[7:3]) * SCREEN_WIDTH + 32'(x));

  assign ren_py   = {1'b0, cursor_row} + {3'd0, rcnt};
  assign ren_addr = AW'(32'(ren_py[8:3]) * SCREEN_WIDTH + 32'(cursor_col) + 32'(ccnt));
  // glyph bit for this column, columns past the row width are background
  assign ren_fg   = !ccnt[4] && gly_q[4'(~ccnt[3:0])];
  assign ren_val  = !(ren_fg ^ color_l) ^ invert;

  // glyph base and row pointer, both wrap at GLYPH_ROWS
  assign base_sum  = {1'b0, gptr} + (GAW+1)'(font_height);
  assign base_next = (base_sum >= (GAW+1)'(GLYPH_ROWS)) ?
                     GAW'(base_sum - (GAW+1)'(GLYPH_ROWS)) : GAW'(base_sum);
  assign row_sum   = {1'b0, gptr} + (GAW+1)'(1);
  assign row_next  = (row_sum >= (GAW+1)'(GLYPH_ROWS)) ?
                     GAW'(row_sum - (GAW+1)'(GLYPH_ROWS)) : GAW'(row_sum);

  // pixel ram port muxing: pending modify has the write port, else the fill sweep
  assign pix_we    = pend || (state == S_FILL);
  assign pix_waddr = pend ? pend_addr : faddr;
  assign pix_wdata = pend ? (pend_val ? (pix_q | pend_mask) : (pix_q & ~pend_mask))
                          : {8{fill_val}};
  assign pix_raddr = (state == S_COLS) ? ren_addr : saddr;

  assign gly_we    = take && (mode == MODE_FONT) && font_ok;
  assign gly_waddr = GAW'(font_index);

  mfgw_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_pixel_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (pix_waddr),
    .wdata (pix_wdata),
    .raddr (pix_raddr),
    .rdata (pix_q)
  );

  mfgw_ram #(
    .WIDTH (16),
    .DEPTH (GLYPH_ROWS)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (gly_we),
    .waddr (gly_waddr),
    .wdata (font_row),
    .raddr (gptr),
    .rdata (gly_q)
  );

  // configuration registers, written at any time the port strobes
  always_ff @(posedge clk) begin
    if (rst) begin
      invert      <= 1'b0;
      font_width  <= FONT_WIDTH_RESET;
      font_height <= FONT_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INVERT:      invert      <= cfg_data[0];
        CFG_FONT_WIDTH:  font_width  <= cfg_data[4:0];
        CFG_FONT_HEIGHT: font_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FILL;    // clearing pass
      faddr      <= '0;
      fill_val   <= 1'b0;
      fill_rep   <= 1'b0;
      pend       <= 1'b0;
      done       <= 1'b0;
      cursor_col <= '0;
      cursor_row <= '0;
    end else begin
      done <= 1'b0;
      pend <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (take) begin
            done         <= 1'b1;
            accepted     <= 1'b0;
            written_char <= '0;
            read_data    <= '0;
            color_l      <= color;
            ch_l         <= ch;
            unique case (mode)
              MODE_FILL: begin
                done     <= 1'b0;
                faddr    <= '0;
                fill_val <= color;
                fill_rep <= 1'b1;
                state    <= S_FILL;
              end
              MODE_PIXEL: begin
                if (pix_ok) begin
                  done      <= 1'b0;
                  saddr     <= pix_addr;
                  pend_addr <= pix_addr;
                  pend_mask <= 8'(1) << y[2:0];
                  pend_val  <= color ^ invert;
                  state     <= S_PIX_RD;
                end
              end
              MODE_CURSOR: begin
                cursor_col <= x;
                cursor_row <= y;
                accepted   <= 1'b1;
              end
              MODE_CHAR: begin
                if (char_ok && fit_ok) begin
                  done  <= 1'b0;
                  kcnt  <= ch[6:0] - FIRST_CHAR[6:0];
                  gptr  <= '0;
                  rcnt  <= '0;
                  state <= S_BASE;
                end
              end
              MODE_FONT: begin
                accepted <= font_ok;
              end
              MODE_READ: begin
                if (read_ok) begin
                  done  <= 1'b0;
                  saddr <= AW'(read_address);
                  state <= S_RD_REQ;
                end
              end
              default: ;
            endcase
          end
        end

        S_FILL: begin
          faddr <= faddr + AW'(1);
          if (faddr == AW'(STORE_BYTES - 1)) begin
            state <= S_IDLE;
            if (fill_rep) begin
              done     <= 1'b1;
              accepted <= 1'b1;
            end
          end
        end

        // draw pixel: read issued here, modify and write back next cycle
        S_PIX_RD: begin
          pend  <= 1'b1;
          state <= S_PIX_WR;
        end

        S_PIX_WR: begin
          done     <= 1'b1;
          accepted <= 1'b1;
          state    <= S_IDLE;
        end

        S_RD_REQ: begin
          state <= S_RD_DATA;
        end

        S_RD_DATA: begin
          done      <= 1'b1;
          accepted  <= 1'b1;
          read_data <= pix_q;
          state     <= S_IDLE;
        end

        // glyph base = (ch - 32) * font_height, one add per cycle
        S_BASE: begin
          if (kcnt == '0) begin
            if (font_height == '0) begin
              cursor_col   <= cursor_col + {3'd0, font_width};
              done         <= 1'b1;
              accepted     <= 1'b1;
              written_char <= ch_l;
              state        <= S_IDLE;
            end else begin
              state <= S_GROW;
            end
          end else begin
            kcnt <= kcnt - 7'd1;
            gptr <= base_next;
          end
        end

        // glyph row read issued from gptr, data valid in S_COLS
        S_GROW: begin
          ccnt  <= '0;
          state <= S_COLS;
        end

        // one column per cycle: read here, write back the next cycle
        S_COLS: begin
          if (ccnt == font_width) begin
            state <= S_RNEXT;
          end else begin
            pend      <= 1'b1;
            pend_addr <= ren_addr;
            pend_mask <= 8'(1) << ren_py[2:0];
            pend_val  <= ren_val;
            ccnt      <= ccnt + 5'd1;
          end
        end

        S_RNEXT: begin
          rcnt <= rcnt + 6'd1;
          gptr <= row_next;
          if ((rcnt + 6'd1) == font_height) begin
            cursor_col   <= cursor_col + {3'd0, font_width};
            done         <= 1'b1;
            accepted     <= 1'b1;
            written_char <= ch_l;
            state        <= S_IDLE;
          end else begin
            state <= S_GROW;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/mfgw_ram.sv */
`timescale 1ns / 1ps

module mfgw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
